[design/dsr_pkg.sv]
// Shared types and constants for the distance speed ramp block.
`default_nettype none
package dsr_pkg;

  localparam int DIST_BITS  = 24;
  localparam int SPEED_BITS = 11;
  localparam int CNT_BITS   = 8;

  // configuration data is as wide as the widest register
  localparam int CFG_W   = (DIST_BITS > SPEED_BITS) ? DIST_BITS : SPEED_BITS;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int DD_W   = DIST_BITS + 1;           // signed distance offset
  localparam int DS_W   = SPEED_BITS + 1;          // signed speed difference
  localparam int PROD_W = DD_W + DS_W;             // signed product
  localparam int MAG_W  = DIST_BITS + SPEED_BITS;  // product magnitude
  localparam int SUM_W  = MAG_W + 2;               // signed quotient plus start speed
  localparam int STEP_W = $clog2(MAG_W + 1);

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DIST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_DIST   = 2'd3;

  typedef struct packed {
    logic [1:0]           operation;
    logic [DIST_BITS-1:0] distance;
  } in_word_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] speed;
    logic                         speed_updated;
    logic                         ramp_running;
    logic                         ramp_finished;
    logic [CNT_BITS-1:0]          completed_ramps;
  } out_word_t;

endpackage
`default_nettype wire

[design/distance_speed_ramp_core.sv]
// Top level of the distance speed ramp: sequencer, restoring divider and output register.
`default_nettype none
// Sequence: start, clear, idle ticks and zero-span ticks go from S_IDLE to S_DONE;
//   a ramp tick goes through S_MUL, S_ABS, S_DIV, S_SUM, S_CLAMP, then S_DONE.
// Throughput: one word at a time; in_stall is high until S_DONE passes the word to a free
//   output register; the restoring divider in S_DIV retires one quotient bit per cycle.
// Reset: synchronous, active low; clears the ramp state, held speed, counter and config registers.
module distance_speed_ramp_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire dsr_pkg::in_word_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      dsr_pkg::out_word_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [dsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dsr_pkg::CFG_W-1:0]     cfg_data
);
  import dsr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_ABS   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_CLAMP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [SPEED_BITS-1:0] start_speed_r, end_speed_r;
  logic [DIST_BITS-1:0]         start_dist_r, span_dist_r;

  // architectural state
  logic                  active_r, active_nxt;
  logic [SPEED_BITS-1:0] held_r, held_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  updated_r, updated_nxt;
  logic                  finished_r, finished_nxt;

  // datapath
  logic [DIST_BITS-1:0]     dist_r, dist_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     neg_r, neg_nxt;
  logic [MAG_W-1:0]         quo_r, quo_nxt;
  logic [DIST_BITS-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  logic in_fire;
  logic out_free;

  logic signed [DD_W-1:0]   dd;
  logic signed [DS_W-1:0]   ds;
  logic [PROD_W-1:0]        prod_abs;
  logic [DIST_BITS:0]       trial_in;
  logic [DIST_BITS:0]       trial;
  logic [MAG_W:0]           quo_ext;
  logic signed [MAG_W:0]    quo_signed;
  logic signed [SUM_W-1:0]  s0_ext, s1_ext, lo_ext, hi_ext, clamped;
  logic                     rising;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // offsets and product operands, read live from the registers
  assign dd = $signed({1'b0, dist_r}) - $signed({1'b0, start_dist_r});
  assign ds = $signed({end_speed_r[SPEED_BITS-1], end_speed_r})
            - $signed({start_speed_r[SPEED_BITS-1], start_speed_r});

  assign prod_abs = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  // one restoring step: bring down the next dividend bit and try the divisor
  assign trial_in = {rem_r, quo_r[MAG_W-1]};
  assign trial    = trial_in - {1'b0, span_dist_r};

  // quotient gets the sign of the product, truncating toward zero
  assign quo_ext    = {1'b0, quo_r};
  assign quo_signed = neg_r ? $signed(-quo_ext) : $signed(quo_ext);

  assign s0_ext = $signed({{(SUM_W-SPEED_BITS){start_speed_r[SPEED_BITS-1]}}, start_speed_r});
  assign s1_ext = $signed({{(SUM_W-SPEED_BITS){end_speed_r[SPEED_BITS-1]}}, end_speed_r});
  assign rising = (s0_ext < s1_ext);
  assign lo_ext = rising ? s0_ext : s1_ext;
  assign hi_ext = rising ? s1_ext : s0_ext;

  always_comb begin
    if (sum_r < lo_ext) begin
      clamped = lo_ext;
    end else if (sum_r > hi_ext) begin
      clamped = hi_ext;
    end else begin
      clamped = sum_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    held_nxt      = held_r;
    count_nxt     = count_r;
    updated_nxt   = updated_r;
    finished_nxt  = finished_r;
    dist_nxt      = dist_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          updated_nxt  = 1'b0;
          finished_nxt = 1'b0;
          dist_nxt     = in_data.distance;
          state_nxt    = S_DONE;
          case (in_data.operation)
            OP_TICK: begin
              if (active_r) begin
                if (span_dist_r == '0) begin
                  // zero span: jump straight to the end speed
                  held_nxt     = end_speed_r;
                  updated_nxt  = 1'b1;
                  finished_nxt = 1'b1;
                  active_nxt   = 1'b0;
                  if (count_r != {CNT_BITS{1'b1}}) begin
                    count_nxt = count_r + 1'b1;
                  end
                end else begin
                  state_nxt = S_MUL;
                end
              end
            end
            OP_START: active_nxt = 1'b1;
            OP_CLEAR: count_nxt  = '0;
            default: ;
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = dd * ds;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        neg_nxt   = prod_r[PROD_W-1];
        quo_nxt   = prod_abs[MAG_W-1:0];
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // quotient bits shift in as dividend bits shift out
        if (!trial[DIST_BITS]) begin
          rem_nxt = trial[DIST_BITS-1:0];
          quo_nxt = {quo_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial_in[DIST_BITS-1:0];
          quo_nxt = {quo_r[MAG_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(MAG_W - 1)) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt   = $signed({quo_signed[MAG_W], quo_signed}) + s0_ext;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        held_nxt    = clamped[SPEED_BITS-1:0];
        updated_nxt = 1'b1;
        if (clamped == s1_ext) begin
          finished_nxt = 1'b1;
          active_nxt   = 1'b0;
          if (count_r != {CNT_BITS{1'b1}}) begin
            count_nxt = count_r + 1'b1;
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.speed           = held_r;
          out_data_nxt.speed_updated   = updated_r;
          out_data_nxt.ramp_running    = active_r;
          out_data_nxt.ramp_finished   = finished_r;
          out_data_nxt.completed_ramps = count_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_r      <= 1'b0;
      held_r        <= '0;
      count_r       <= '0;
      updated_r     <= 1'b0;
      finished_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      start_speed_r <= '0;
      end_speed_r   <= '0;
      start_dist_r  <= '0;
      span_dist_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      held_r      <= held_nxt;
      count_r     <= count_nxt;
      updated_r   <= updated_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_SPEED: start_speed_r <= cfg_data[SPEED_BITS-1:0];
          REG_END_SPEED:   end_speed_r   <= cfg_data[SPEED_BITS-1:0];
          REG_START_DIST:  start_dist_r  <= cfg_data[DIST_BITS-1:0];
          REG_SPAN_DIST:   span_dist_r   <= cfg_data[DIST_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
